// File: sv/cpm_pkg.sv
// Shared types, constants and helpers of the cascaded PID and motor mixer block.
package cpm_pkg;

  // Datapath widths.
  localparam int ACC_W = 48;  // accumulator and dividend width
  localparam int MB_W  = 28;  // serial multiplier operand width, one bit per cycle
  localparam int DV_W  = 16;  // constant divisor width
  localparam int VAL_W = 32;  // converted input and mixer values
  localparam int LV_W  = 24;  // loop state values

  localparam int FRAC_BITS_DEF = 8;
  localparam int DUTY_BITS_DEF = 12;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [LV_W-1:0]  lv_t;

  // Start request for the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

  localparam acc_t VMAX     = acc_t'(8388607);
  localparam int   THR_MAX  = 900000;
  localparam int   THR_RUN  = 10000;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_ANGLE_KP = 4'd0,
    REG_ANGLE_KD = 4'd1,
    REG_RATE_KP  = 4'd2,
    REG_RATE_KI  = 4'd3,
    REG_RATE_KD  = 4'd4,
    REG_YAW_KP   = 4'd5,
    REG_YAW_KI   = 4'd6,
    REG_YAW_KD   = 4'd7
  } reg_idx_e;

  // Saturate a value into a signed window.
  function automatic acc_t clamp_acc(acc_t v, acc_t lo, acc_t hi);
    acc_t r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// File: sv/cpm_mac.sv
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle.
module cpm_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cpm_pkg::mac_ctl_t            ctl_i,
  input  cpm_pkg::acc_t                a_i,
  input  logic [cpm_pkg::MB_W-1:0]     b_i,
  output logic                         done_o,
  output cpm_pkg::acc_t                acc_o
);
  import cpm_pkg::*;

  localparam int CNT_W = $clog2(MB_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  acc_t             a_q, acc_q;
  logic [MB_W-1:0]  b_q;

  // Sequencing of the shift-add pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MB_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand shifting and accumulation.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q <= a_i;
      b_q <= b_i;
      if (ctl_i.clear) acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

// File: sv/cpm_div.sv
// Bit-serial restoring divider by a small constant, rounding to nearest, ties away from zero.
module cpm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  cpm_pkg::acc_t              n_i,
  input  logic [cpm_pkg::DV_W-1:0]   d_i,
  output logic                       done_o,
  output cpm_pkg::acc_t              q_o
);
  import cpm_pkg::*;

  localparam int CNT_W = $clog2(ACC_W);

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] num_q, mag;
  logic [DV_W-1:0]  rem_q, d_q, rem_d;
  logic [DV_W:0]    trial;
  logic             ge;

  // Magnitude of the dividend and one quotient bit per cycle.
  always_comb begin
    mag   = n_i[ACC_W-1] ? ACC_W'(-n_i) : ACC_W'(n_i);
    trial = {rem_q, num_q[ACC_W-1]};
    ge    = trial >= {1'b0, d_q};
    rem_d = ge ? DV_W'(trial - {1'b0, d_q}) : DV_W'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= mag + ACC_W'(d_i >> 1);
      rem_q <= '0;
      d_q   <= d_i;
      neg_q <= n_i[ACC_W-1];
    end else if (busy_q) begin
      num_q <= {num_q[ACC_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? -acc_t'(num_q) : acc_t'(num_q);

endmodule

// File: sv/quadrotor_cascaded_pid_mixer_top.sv
// Top level: sequencer over a serial multiplier and divider running the PID loops and mixer.
//
//  channel  | direction | beat contents
//  s_axis   | in        | tdata: stick_pitch, stick_roll, stick_throttle, stick_yaw,
//           |           |        angle_pitch_raw, angle_roll_raw, rate_pitch_raw,
//           |           |        rate_roll_raw, rate_yaw_raw; tuser: armed
//  m_axis   | out       | tdata: motor_front_a, motor_front_b, motor_rear_a, motor_rear_b
//  cfg      | in        | write enable, register index, 16-bit gain
//
// One beat takes 33 micro-steps: 23 of them multiply then divide, and 10 only
// multiply-accumulate; the mixer result is then loaded into the output register
// and the block returns to idle before the next beat is accepted.
// Reset clears the gains to their defaults, the loop state and the throttle.
// A new beat is taken once the previous one is done; a stalled result waits
// in the output register and holds only the final step of the next beat.
module quadrotor_cascaded_pid_mixer_top #(
  parameter int FRAC_BITS = cpm_pkg::FRAC_BITS_DEF,
  parameter int DUTY_BITS = cpm_pkg::DUTY_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // stick_pitch, stick_roll, stick_throttle, stick_yaw, angle_pitch_raw,
  // angle_roll_raw, rate_pitch_raw, rate_roll_raw, rate_yaw_raw, zero pad
  input  logic [127:0]                         s_axis_tdata,
  // armed
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b, zero pad
  output logic [((4*DUTY_BITS+7)/8)*8-1:0]     m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [3:0]                           cfg_idx_i,
  input  logic [15:0]                          cfg_data_i
);
  import cpm_pkg::*;

  localparam int OUT_W = ((4*DUTY_BITS+7)/8)*8;
  localparam logic [MB_W-1:0] B_ONE  = MB_W'(1 << FRAC_BITS);
  localparam logic [MB_W-1:0] B_180  = MB_W'(180 << FRAC_BITS);
  localparam logic [MB_W-1:0] B_2000 = MB_W'(2000 << FRAC_BITS);
  localparam acc_t I_LIM   = acc_t'(100 << FRAC_BITS);
  localparam acc_t OUT_TOP = acc_t'(300 << FRAC_BITS);
  localparam val_t DUTY_MAX = val_t'((1 << DUTY_BITS) - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ISSUE = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_WB    = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    SUB_TGT = 3'd0,
    SUB_INT = 3'd1,
    SUB_P   = 3'd2,
    SUB_I   = 3'd3,
    SUB_D   = 3'd4
  } sub_e;

  state_e      state_q;
  logic        phase_q;
  logic [2:0]  pstep_q, k_q;
  sub_e        sub_q;

  logic [15:0] angle_kp_q, angle_kd_q, rate_kp_q, rate_ki_q, rate_kd_q;
  logic [15:0] yaw_kp_q, yaw_ki_q, yaw_kd_q;

  lv_t         integ_q [5];
  lv_t         prev_q  [5];
  logic [19:0] thl_q;
  logic        m_valid_q;

  logic signed [10:0] sp_q, sr_q, sy_q;
  logic signed [15:0] rap_q, rar_q, rrp_q, rrr_q, rry_q;
  logic               armed_q;
  val_t               cv_q [8];
  lv_t                lo_q [5];
  lv_t                e_q, i_q;
  logic signed [LV_W:0] dd_q;
  logic [OUT_W-1:0]   out_q;

  logic               accept;
  logic               out_load;
  mac_ctl_t           mac_ctl;
  acc_t               op_a, mac_acc, div_q, res, diff, ival, oval;
  logic [MB_W-1:0]    op_b;
  logic               op_div, mac_done, div_done, div_start, last_step;
  logic [DV_W-1:0]    op_d;
  logic [15:0]        kp_sel, ki_sel, kd_sel;
  logic signed [21:0] tsum;
  logic [19:0]        thl_new;
  val_t               m [4];
  logic [DUTY_BITS-1:0] duty [4];
  logic               run;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // Gains of the loop that the current step works on.
  always_comb begin
    if (k_q < 3'd2) begin
      kp_sel = angle_kp_q;
      ki_sel = '0;
      kd_sel = angle_kd_q;
    end else if (k_q < 3'd4) begin
      kp_sel = rate_kp_q;
      ki_sel = rate_ki_q;
      kd_sel = rate_kd_q;
    end else begin
      kp_sel = yaw_kp_q;
      ki_sel = yaw_ki_q;
      kd_sel = yaw_kd_q;
    end
  end

  // Operands of the current micro-step.
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_div = 1'b1;
    op_d   = DV_W'(1);
    mac_ctl.start = (state_q == ST_ISSUE);
    mac_ctl.clear = 1'b1;
    if (!phase_q) begin
      unique case (pstep_q)
        3'd0: begin op_a = acc_t'(rap_q);  op_b = B_180;  op_d = DV_W'(32768); end
        3'd1: begin op_a = acc_t'(rar_q);  op_b = B_180;  op_d = DV_W'(32768); end
        3'd2: begin op_a = acc_t'(rrp_q);  op_b = B_2000; op_d = DV_W'(32768); end
        3'd3: begin op_a = -acc_t'(rrr_q); op_b = B_2000; op_d = DV_W'(32768); end
        3'd4: begin op_a = acc_t'(rry_q);  op_b = B_2000; op_d = DV_W'(32768); end
        3'd5: begin op_a = acc_t'(sp_q);   op_b = B_ONE;  op_d = DV_W'(20);    end
        3'd6: begin op_a = acc_t'(sr_q);   op_b = B_ONE;  op_d = DV_W'(20);    end
        default: begin op_a = acc_t'({1'b0, thl_q}); op_b = B_ONE; op_d = DV_W'(1000); end
      endcase
    end else begin
      unique case (sub_q)
        SUB_TGT: begin
          unique case (k_q)
            3'd0: begin op_a = -acc_t'(sp_q); op_b = B_ONE; op_d = DV_W'(50); end
            3'd1: begin op_a = acc_t'(sr_q);  op_b = B_ONE; op_d = DV_W'(50); end
            3'd2: begin op_a = acc_t'(lo_q[0]); op_b = MB_W'(1); end
            3'd3: begin op_a = acc_t'(lo_q[1]); op_b = MB_W'(1); end
            default: begin op_a = acc_t'(sy_q); op_b = B_ONE; op_d = DV_W'(20); end
          endcase
        end
        SUB_INT: begin
          op_a = acc_t'(integ_q[k_q]) + acc_t'(e_q);
          op_b = MB_W'(19);
          op_d = DV_W'(20);
        end
        SUB_P: begin
          op_a   = acc_t'(e_q);
          op_b   = MB_W'(kp_sel);
          op_div = 1'b0;
        end
        SUB_I: begin
          op_a   = acc_t'(i_q);
          op_b   = MB_W'(ki_sel);
          op_div = 1'b0;
          mac_ctl.clear = 1'b0;
        end
        default: begin
          op_a = -acc_t'(dd_q);
          op_b = MB_W'(kd_sel);
          op_d = DV_W'(4096);
          mac_ctl.clear = 1'b0;
        end
      endcase
    end
  end

  assign div_start     = (state_q == ST_MAC) && mac_done && op_div;
  assign last_step     = phase_q && (sub_q == SUB_D) && (k_q == 3'd4);

  cpm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  cpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (mac_acc),
    .d_i     (op_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Write-back values of the loop steps.
  always_comb begin
    res  = op_div ? div_q : mac_acc;
    diff = clamp_acc(res - acc_t'(cv_q[k_q]), -VMAX, VMAX);
    ival = clamp_acc(res, -I_LIM, I_LIM);
    if ((e_q > 0 && ival > 0) || (e_q < 0 && ival < 0)) ival = '0;
    oval = clamp_acc(res, -VMAX, OUT_TOP);
  end

  // Throttle integration, taken when a beat is accepted.
  always_comb begin
    tsum = $signed({2'b00, thl_q}) + 22'(signed'(s_axis_tdata[32:22]));
    if (tsum < 0) thl_new = '0;
    else if (tsum > 22'(THR_MAX)) thl_new = 20'(THR_MAX);
    else thl_new = tsum[19:0];
  end

  // X mixer and duty conversion.
  always_comb begin
    m[0] = cv_q[7] + val_t'(lo_q[3]) + cv_q[6] + val_t'(lo_q[2]) - cv_q[5] + val_t'(lo_q[4]);
    m[1] = cv_q[7] + val_t'(lo_q[3]) + cv_q[6] - val_t'(lo_q[2]) + cv_q[5] - val_t'(lo_q[4]);
    m[2] = cv_q[7] - val_t'(lo_q[3]) - cv_q[6] + val_t'(lo_q[2]) - cv_q[5] - val_t'(lo_q[4]);
    m[3] = cv_q[7] - val_t'(lo_q[3]) - cv_q[6] - val_t'(lo_q[2]) + cv_q[5] + val_t'(lo_q[4]);
    run  = armed_q && (thl_q > 20'(THR_RUN));
    for (int j = 0; j < 4; j++) begin
      if (!run || m[j] <= 0) duty[j] = '0;
      else if ((m[j] >>> FRAC_BITS) > DUTY_MAX) duty[j] = DUTY_MAX[DUTY_BITS-1:0];
      else duty[j] = DUTY_BITS'(m[j] >>> FRAC_BITS);
    end
  end

  // Control, gains and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= 1'b0;
      pstep_q    <= '0;
      k_q        <= '0;
      sub_q      <= SUB_TGT;
      m_valid_q  <= 1'b0;
      thl_q      <= '0;
      angle_kp_q <= 16'd5325;
      angle_kd_q <= 16'd819;
      rate_kp_q  <= 16'd4915;
      rate_ki_q  <= 16'd82;
      rate_kd_q  <= 16'd2458;
      yaw_kp_q   <= 16'd15565;
      yaw_ki_q   <= 16'd2253;
      yaw_kd_q   <= 16'd410;
      for (int j = 0; j < 5; j++) begin
        integ_q[j] <= '0;
        prev_q[j]  <= '0;
      end
    end else begin
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ANGLE_KP: angle_kp_q <= cfg_data_i;
          REG_ANGLE_KD: angle_kd_q <= cfg_data_i;
          REG_RATE_KP:  rate_kp_q  <= cfg_data_i;
          REG_RATE_KI:  rate_ki_q  <= cfg_data_i;
          REG_RATE_KD:  rate_kd_q  <= cfg_data_i;
          REG_YAW_KP:   yaw_kp_q   <= cfg_data_i;
          REG_YAW_KI:   yaw_ki_q   <= cfg_data_i;
          REG_YAW_KD:   yaw_kd_q   <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            thl_q   <= thl_new;
            phase_q <= 1'b0;
            pstep_q <= '0;
            k_q     <= '0;
            sub_q   <= SUB_TGT;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_q <= ST_MAC;
        ST_MAC: begin
          if (mac_done) state_q <= op_div ? ST_DIV : ST_WB;
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_WB;
        end
        ST_WB: begin
          if (phase_q && sub_q == SUB_INT) begin
            integ_q[k_q] <= lv_t'(ival);
            prev_q[k_q]  <= e_q;
          end
          if (last_step) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_ISSUE;
            if (!phase_q) begin
              if (pstep_q == 3'd7) phase_q <= 1'b1;
              else pstep_q <= pstep_q + 3'd1;
            end else if (sub_q == SUB_D) begin
              sub_q <= SUB_TGT;
              k_q   <= k_q + 3'd1;
            end else begin
              sub_q <= sub_e'(sub_q + 3'd1);
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            if (!armed_q) thl_q <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Captured beat fields and intermediate values.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sp_q    <= s_axis_tdata[10:0];
      sr_q    <= s_axis_tdata[21:11];
      sy_q    <= s_axis_tdata[43:33];
      rap_q   <= s_axis_tdata[59:44];
      rar_q   <= s_axis_tdata[75:60];
      rrp_q   <= s_axis_tdata[91:76];
      rrr_q   <= s_axis_tdata[107:92];
      rry_q   <= s_axis_tdata[123:108];
      armed_q <= s_axis_tuser;
    end
    if (state_q == ST_WB) begin
      if (!phase_q) begin
        cv_q[pstep_q] <= val_t'(res);
      end else begin
        unique case (sub_q)
          SUB_TGT: e_q <= lv_t'(diff);
          SUB_INT: begin
            i_q  <= lv_t'(ival);
            dd_q <= (LV_W+1)'(e_q) - (LV_W+1)'(prev_q[k_q]);
          end
          SUB_D:   lo_q[k_q] <= lv_t'(oval);
          default: ;
        endcase
      end
    end
    if (out_load) begin
      out_q <= OUT_W'({duty[3], duty[2], duty[1], duty[0]});
    end
  end

`ifndef NO_ASSERTIONS
  a_thl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thl_q <= 20'(THR_MAX))
    else $error("throttle level above its limit");

  a_loop_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(phase_q && k_q > 3'd4))
    else $error("loop index out of range");

  a_wb_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WB |=> state_q != ST_WB)
    else $error("write-back lasted more than one cycle");

  a_mac_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ST_MAC)
    else $error("multiplier finished outside its wait state");
`endif

endmodule
